// ===== rtl/core/uct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uct_pkg;

    // parser modes
    typedef enum logic [2:0]
    {
        MODE_START,
        MODE_UNQUOTED,
        MODE_QUOTED,
        MODE_QCR,
        MODE_QSEEN,
        MODE_AFTER_CR,
        MODE_HALT
    } mode_t;

    // result kinds, carried on the output tuser
    typedef enum logic [1:0]
    {
        KIND_BYTE,
        KIND_FIELD,
        KIND_ROW,
        KIND_ERR
    } kind_t;

    typedef enum logic [2:0]
    {
        ERR_NONE,
        ERR_UTF8,
        ERR_UNCLOSED,
        ERR_STRAY,
        ERR_SEP
    } err_t;

    // bounds for the next utf-8 continuation byte
    typedef enum logic [1:0]
    {
        RANGE_NORMAL,
        RANGE_RAISED,
        RANGE_LOWERED
    } range_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] BOM_0    = 8'hEF;
    localparam logic [7:0] BOM_1    = 8'hBB;
    localparam logic [7:0] BOM_2    = 8'hBF;

    localparam int RES_MAX = 4;

    typedef struct packed
    {
        kind_t      kind;
        logic [7:0] data;
        err_t       err;
    } res_t;

    typedef struct packed
    {
        mode_t       mode;
        logic        row_open;
        logic [1:0]  u_left;
        range_t      u_range;
        logic        at_start;
        logic [15:0] held;
        logic [1:0]  held_cnt;
    } pst_t;

    // parser state plus the results gathered so far for one input byte
    typedef struct packed
    {
        pst_t                     st;
        res_t [RES_MAX-1:0]       res;
        logic [$clog2(RES_MAX):0] n;
    } acc_t;

    localparam pst_t ST_RESET = '{
        mode:     MODE_START,
        row_open: 1'b0,
        u_left:   2'd0,
        u_range:  RANGE_NORMAL,
        at_start: 1'b1,
        held:     16'h0000,
        held_cnt: 2'd0
    };

    function automatic acc_t emit(acc_t a, kind_t k, logic [7:0] d, err_t e);
        acc_t r;
        r = a;
        if (r.n < ($clog2(RES_MAX)+1)'(RES_MAX))
        begin
            r.res[r.n[$clog2(RES_MAX)-1:0]].kind = k;
            r.res[r.n[$clog2(RES_MAX)-1:0]].data = d;
            r.res[r.n[$clog2(RES_MAX)-1:0]].err  = e;
            r.n = r.n + 1'b1;
        end
        return r;
    endfunction

    function automatic acc_t fail(acc_t a, err_t e);
        acc_t r;
        r = emit(a, KIND_ERR, 8'h00, e);
        r.st.mode = MODE_HALT;
        return r;
    endfunction

    function automatic logic is_sep(logic [7:0] c);
        return (c == CH_COMMA) || (c == CH_LF) || (c == CH_CR);
    endfunction

    // separator after a closed field, caller has checked is_sep
    function automatic acc_t apply_sep(acc_t a, logic [7:0] c);
        acc_t r;
        r = a;
        if (c == CH_COMMA)
        begin
            r = emit(r, KIND_FIELD, 8'h00, ERR_NONE);
            r.st.mode = MODE_START;
            r.st.row_open = 1'b1;
        end
        else if (c == CH_LF)
        begin
            r = emit(r, KIND_ROW, 8'h00, ERR_NONE);
            r.st.mode = MODE_START;
            r.st.row_open = 1'b0;
        end
        else
        begin
            r.st.mode = MODE_AFTER_CR;
        end
        return r;
    endfunction

    function automatic acc_t quoted_byte(acc_t a, logic [7:0] c);
        acc_t r;
        r = a;
        if (c == CH_QUOTE)
            r.st.mode = MODE_QSEEN;
        else if (c == CH_CR)
            r.st.mode = MODE_QCR;
        else
            r = emit(r, KIND_BYTE, c, ERR_NONE);
        return r;
    endfunction

    function automatic acc_t csv_byte(acc_t a, logic [7:0] c);
        acc_t r;
        r = a;
        unique case (r.st.mode)
            MODE_START:
            begin
                if (c == CH_QUOTE)
                begin
                    r.st.mode = MODE_QUOTED;
                    r.st.row_open = 1'b1;
                end
                else if (is_sep(c))
                begin
                    r = apply_sep(r, c);
                end
                else
                begin
                    r = emit(r, KIND_BYTE, c, ERR_NONE);
                    r.st.mode = MODE_UNQUOTED;
                    r.st.row_open = 1'b1;
                end
            end
            MODE_UNQUOTED:
            begin
                if (c == CH_QUOTE)
                    r = fail(r, ERR_STRAY);
                else if (is_sep(c))
                    r = apply_sep(r, c);
                else
                    r = emit(r, KIND_BYTE, c, ERR_NONE);
            end
            MODE_QUOTED:
            begin
                r = quoted_byte(r, c);
            end
            MODE_QCR:
            begin
                r.st.mode = MODE_QUOTED;
                if (c == CH_LF)
                begin
                    r = emit(r, KIND_BYTE, CH_LF, ERR_NONE);
                end
                else
                begin
                    r = emit(r, KIND_BYTE, CH_CR, ERR_NONE);
                    r = quoted_byte(r, c);
                end
            end
            MODE_QSEEN:
            begin
                if (c == CH_QUOTE)
                begin
                    r = emit(r, KIND_BYTE, CH_QUOTE, ERR_NONE);
                    r.st.mode = MODE_QUOTED;
                end
                else if (is_sep(c))
                begin
                    r = apply_sep(r, c);
                end
                else
                begin
                    r = fail(r, ERR_SEP);
                end
            end
            MODE_AFTER_CR:
            begin
                if (c == CH_LF)
                begin
                    r = emit(r, KIND_ROW, 8'h00, ERR_NONE);
                    r.st.mode = MODE_START;
                    r.st.row_open = 1'b0;
                end
                else
                begin
                    r = fail(r, ERR_SEP);
                end
            end
            default:
            begin
                r.st.mode = MODE_HALT;
            end
        endcase
        return r;
    endfunction

    // utf-8 check, then csv handling
    function automatic acc_t full_byte(acc_t a, logic [7:0] c);
        acc_t       r;
        logic       ok;
        logic [7:0] lo;
        logic [7:0] hi;
        r = a;
        ok = 1'b1;
        lo = 8'h80;
        hi = 8'hBF;
        if (r.st.mode != MODE_HALT)
        begin
            if (r.st.u_left != 2'd0)
            begin
                if (r.st.u_range == RANGE_RAISED)
                    lo = (r.st.u_left == 2'd3) ? 8'h90 : 8'hA0;
                if (r.st.u_range == RANGE_LOWERED)
                    hi = (r.st.u_left == 2'd3) ? 8'h8F : 8'h9F;
                ok = (c >= lo) && (c <= hi);
                if (ok)
                begin
                    r.st.u_range = RANGE_NORMAL;
                    r.st.u_left = r.st.u_left - 2'd1;
                end
            end
            else if (c == CH_NUL)
            begin
                ok = 1'b0;
            end
            else if (c < 8'h80)
            begin
                ok = 1'b1;
            end
            else if ((c < 8'hC2) || (c > 8'hF4))
            begin
                ok = 1'b0;
            end
            else if (c < 8'hE0)
            begin
                r.st.u_left = 2'd1;
            end
            else if (c < 8'hF0)
            begin
                r.st.u_left = 2'd2;
                r.st.u_range = (c == 8'hE0) ? RANGE_RAISED :
                               (c == 8'hED) ? RANGE_LOWERED : RANGE_NORMAL;
            end
            else
            begin
                r.st.u_left = 2'd3;
                r.st.u_range = (c == 8'hF0) ? RANGE_RAISED :
                               (c == 8'hF4) ? RANGE_LOWERED : RANGE_NORMAL;
            end
            if (!ok)
                r = fail(r, ERR_UTF8);
            else
                r = csv_byte(r, c);
        end
        return r;
    endfunction

    // push back the bytes held as a possible byte-order mark
    function automatic acc_t release_held(acc_t a);
        acc_t        r;
        logic [15:0] p;
        logic [1:0]  cnt;
        r = a;
        p = r.st.held;
        cnt = r.st.held_cnt;
        r.st.held_cnt = 2'd0;
        r.st.at_start = 1'b0;
        if (cnt >= 2'd2)
        begin
            r = full_byte(r, p[15:8]);
            r = full_byte(r, p[7:0]);
        end
        else if (cnt == 2'd1)
        begin
            r = full_byte(r, p[7:0]);
        end
        r.st.held = 16'h0000;
        return r;
    endfunction

    function automatic acc_t text_end(acc_t a);
        acc_t r;
        r = a;
        if (r.st.mode != MODE_HALT)
        begin
            if (r.st.u_left != 2'd0)
            begin
                r = fail(r, ERR_UTF8);
            end
            else
            begin
                unique case (r.st.mode)
                    MODE_START:
                    begin
                        if (r.st.row_open)
                            r = emit(r, KIND_ROW, 8'h00, ERR_NONE);
                    end
                    MODE_UNQUOTED, MODE_QSEEN:
                    begin
                        r = emit(r, KIND_ROW, 8'h00, ERR_NONE);
                    end
                    MODE_QUOTED, MODE_QCR:
                    begin
                        r = fail(r, ERR_UNCLOSED);
                    end
                    default:
                    begin
                        r = fail(r, ERR_SEP);
                    end
                endcase
            end
        end
        return r;
    endfunction

    // whole handling of one input byte
    function automatic acc_t step(pst_t s, logic [7:0] c, logic last);
        acc_t       r;
        logic [1:0] idx;
        logic [7:0] bom;
        r.st = s;
        r.res = '0;
        r.n = '0;
        if (s.mode != MODE_HALT)
        begin
            if (s.at_start)
            begin
                idx = (s.held_cnt > 2'd2) ? 2'd2 : s.held_cnt;
                bom = (idx == 2'd0) ? BOM_0 : (idx == 2'd1) ? BOM_1 : BOM_2;
                if (c == bom)
                begin
                    if (idx == 2'd2)
                    begin
                        r.st.held = 16'h0000;
                        r.st.held_cnt = 2'd0;
                        r.st.at_start = 1'b0;
                    end
                    else
                    begin
                        r.st.held = {r.st.held[7:0], c};
                        r.st.held_cnt = idx + 2'd1;
                        if (last)
                            r = release_held(r);
                    end
                end
                else
                begin
                    r = release_held(r);
                    r = full_byte(r, c);
                end
            end
            else
            begin
                r = full_byte(r, c);
            end
            if (last)
            begin
                r = text_end(r);
                if (r.st.mode != MODE_HALT)
                    r.st = ST_RESET;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utf8_csv_tokenizer.sv =====
// a taken byte waits in the input stage; its results are registered in the result group
// throughput: one byte per cycle while each byte gives at most one result and m_tready holds;
//   a byte that gives n results (n up to 4) holds the result group until all n are taken, and
// the output port moves one result per transfer, which sets the peak rate
// reset: rst_n low clears the parser state and empties both stages at once
`timescale 1ns / 1ps
`default_nettype none

module utf8_csv_tokenizer
    import uct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // is_last
    // token stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] error_code, [15:11] zero
    output logic [1:0]       m_tuser,   // [1:0] out_kind
    output logic             m_tlast    // run_last
);

    localparam int IDX_W = $clog2(RES_MAX);

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parser state
    pst_t st_reg;

    // result group of the byte last processed, drained one result a transfer
    logic               grp_valid_reg;
    res_t [RES_MAX-1:0] grp_res_reg;
    logic [IDX_W:0]     grp_cnt_reg;
    logic [IDX_W-1:0]   grp_idx_reg;

    acc_t acc;
    logic out_xfer;
    logic grp_done;
    logic move;
    res_t cur;

    // all parsing of the held byte happens in this one cloud
    always_comb
    begin
        acc = step(st_reg, in_byte_reg, in_last_reg);
    end

    assign cur      = grp_res_reg[grp_idx_reg];
    assign m_tvalid = grp_valid_reg;
    assign m_tlast  = ({1'b0, grp_idx_reg} + 1'b1) == grp_cnt_reg;
    assign m_tuser  = cur.kind;
    assign m_tdata  = {5'b00000, cur.err, cur.data};

    assign out_xfer = m_tvalid && m_tready;
    assign grp_done = out_xfer && m_tlast;
    // the held byte moves on once the result group is free or frees now
    assign move     = in_valid_reg && (!grp_valid_reg || grp_done);
    assign s_tready = !in_valid_reg || move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            st_reg        <= ST_RESET;
            grp_valid_reg <= 1'b0;
            grp_cnt_reg   <= '0;
            grp_idx_reg   <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;

            if (move)
            begin
                st_reg        <= acc.st;
                grp_valid_reg <= (acc.n != '0);
                grp_cnt_reg   <= acc.n;
                grp_idx_reg   <= '0;
            end
            else if (grp_done)
            begin
                grp_valid_reg <= 1'b0;
            end
            else if (out_xfer)
            begin
                grp_idx_reg <= grp_idx_reg + 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (move)
            grp_res_reg <= acc.res;
    end

endmodule

`default_nettype wire

// ===== rtl/core/uct_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uct_chk
    import uct_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // error code is set exactly on error results
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == KIND_ERR) == (m_tdata[10:8] != 3'd0)))
        else $error("error code and kind disagree");

    // byte field only carries data on content results, pad bits stay zero on the others
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_BYTE) |-> (m_tdata[7:0] == 8'h00)
            && (m_tdata[15:11] == 5'd0))
        else $error("stray payload bits");

    // an error ends its run
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ERR) |-> m_tlast)
        else $error("error not final in run");

    // nothing follows an error
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == KIND_ERR) |=> !m_tvalid)
        else $error("result after error");

endmodule

bind utf8_csv_tokenizer uct_chk u_chk (.*);

`default_nettype wire

// ===== tb/uct_tb_pkg.sv =====
`timescale 1ns / 1ps

package uct_tb_pkg;

    import uct_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // one token as it leaves the tokenizer
    typedef struct packed
    {
        kind_t      kind;
        logic [7:0] data;
        err_t       err;
        logic       last;
    } token_t;

    // tracks the tokenizer state and the tokens still owed by the block
    class csv_tokens;

        mode_t       mode;
        logic        in_row;
        logic [1:0]  cont_left;
        range_t      cont_range;
        logic        text_head;
        logic [15:0] mark_bytes;
        logic [1:0]  mark_len;

        token_t      step_out[$];
        token_t      pending[$];
        int          checked;
        int          errors;
        err_t        seen_err;

        function new();
            restart();
            checked  = 0;
            errors   = 0;
            seen_err = ERR_NONE;
        endfunction

        function void restart();
            mode       = MODE_START;
            in_row     = 1'b0;
            cont_left  = 2'd0;
            cont_range = RANGE_NORMAL;
            text_head  = 1'b1;
            mark_bytes = 16'h0000;
            mark_len   = 2'd0;
        endfunction

        function void put(kind_t k, logic [7:0] d, err_t e);
            token_t t;
            if (step_out.size() < RES_MAX)
            begin
                t.kind = k;
                t.data = d;
                t.err  = e;
                t.last = 1'b0;
                step_out = {step_out, t};
            end
        endfunction

        function void stop(err_t e);
            put(KIND_ERR, 8'h00, e);
            mode = MODE_HALT;
        endfunction

        // strict utf-8: no NUL, no overlongs, no surrogates, nothing above U+10FFFF
        function bit utf8_fits(logic [7:0] c);
            logic [7:0] lo;
            logic [7:0] hi;
            if (cont_left != 2'd0)
            begin
                lo = 8'h80;
                hi = 8'hBF;
                if (cont_range == RANGE_RAISED)
                    lo = (cont_left == 2'd3) ? 8'h90 : 8'hA0;
                else if (cont_range == RANGE_LOWERED)
                    hi = (cont_left == 2'd3) ? 8'h8F : 8'h9F;
                if (c < lo || c > hi)
                    return 1'b0;
                cont_range = RANGE_NORMAL;
                cont_left  = cont_left - 2'd1;
                return 1'b1;
            end
            if (c == CH_NUL)
                return 1'b0;
            if (c < 8'h80)
                return 1'b1;
            if (c < 8'hC2 || c > 8'hF4)
                return 1'b0;
            if (c < 8'hE0)
            begin
                cont_left = 2'd1;
            end
            else if (c < 8'hF0)
            begin
                cont_left  = 2'd2;
                cont_range = (c == 8'hE0) ? RANGE_RAISED :
                             (c == 8'hED) ? RANGE_LOWERED : RANGE_NORMAL;
            end
            else
            begin
                cont_left  = 2'd3;
                cont_range = (c == 8'hF0) ? RANGE_RAISED :
                             (c == 8'hF4) ? RANGE_LOWERED : RANGE_NORMAL;
            end
            return 1'b1;
        endfunction

        function bit ends_field(logic [7:0] c);
            if (c == CH_COMMA)
            begin
                put(KIND_FIELD, 8'h00, ERR_NONE);
                mode   = MODE_START;
                in_row = 1'b1;
            end
            else if (c == CH_LF)
            begin
                put(KIND_ROW, 8'h00, ERR_NONE);
                mode   = MODE_START;
                in_row = 1'b0;
            end
            else if (c == CH_CR)
            begin
                mode = MODE_AFTER_CR;
            end
            else
            begin
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void in_quotes(logic [7:0] c);
            if (c == CH_QUOTE)
                mode = MODE_QSEEN;
            else if (c == CH_CR)
                mode = MODE_QCR;
            else
                put(KIND_BYTE, c, ERR_NONE);
        endfunction

        function void parse_char(logic [7:0] c);
            case (mode)
                MODE_START:
                begin
                    if (c == CH_QUOTE)
                    begin
                        mode   = MODE_QUOTED;
                        in_row = 1'b1;
                    end
                    else if (!ends_field(c))
                    begin
                        put(KIND_BYTE, c, ERR_NONE);
                        mode   = MODE_UNQUOTED;
                        in_row = 1'b1;
                    end
                end
                MODE_UNQUOTED:
                begin
                    if (c == CH_QUOTE)
                        stop(ERR_STRAY);
                    else if (!ends_field(c))
                        put(KIND_BYTE, c, ERR_NONE);
                end
                MODE_QUOTED:
                begin
                    in_quotes(c);
                end
                MODE_QCR:
                begin
                    mode = MODE_QUOTED;
                    if (c == CH_LF)
                    begin
                        put(KIND_BYTE, CH_LF, ERR_NONE);
                    end
                    else
                    begin
                        put(KIND_BYTE, CH_CR, ERR_NONE);
                        in_quotes(c);
                    end
                end
                MODE_QSEEN:
                begin
                    if (c == CH_QUOTE)
                    begin
                        put(KIND_BYTE, CH_QUOTE, ERR_NONE);
                        mode = MODE_QUOTED;
                    end
                    else if (!ends_field(c))
                    begin
                        stop(ERR_SEP);
                    end
                end
                MODE_AFTER_CR:
                begin
                    if (c == CH_LF)
                    begin
                        put(KIND_ROW, 8'h00, ERR_NONE);
                        mode   = MODE_START;
                        in_row = 1'b0;
                    end
                    else
                    begin
                        stop(ERR_SEP);
                    end
                end
                default:
                begin
                    mode = MODE_HALT;
                end
            endcase
        endfunction

        function void feed(logic [7:0] c);
            if (mode == MODE_HALT)
                return;
            if (!utf8_fits(c))
            begin
                stop(ERR_UTF8);
                return;
            end
            parse_char(c);
        endfunction

        // bytes kept back as a possible byte-order mark go through in order
        function void release_mark();
            logic [1:0] cnt;
            cnt        = (mark_len > 2'd2) ? 2'd2 : mark_len;
            mark_len   = 2'd0;
            text_head  = 1'b0;
            if (cnt == 2'd2)
            begin
                feed(mark_bytes[15:8]);
                feed(mark_bytes[7:0]);
            end
            else if (cnt == 2'd1)
            begin
                feed(mark_bytes[7:0]);
            end
            mark_bytes = 16'h0000;
        endfunction

        function void finish_text();
            if (mode == MODE_HALT)
                return;
            if (cont_left != 2'd0)
            begin
                stop(ERR_UTF8);
                return;
            end
            case (mode)
                MODE_START:
                begin
                    if (in_row)
                        put(KIND_ROW, 8'h00, ERR_NONE);
                end
                MODE_UNQUOTED, MODE_QSEEN:
                begin
                    put(KIND_ROW, 8'h00, ERR_NONE);
                end
                MODE_QUOTED, MODE_QCR:
                begin
                    stop(ERR_UNCLOSED);
                end
                default:
                begin
                    stop(ERR_SEP);
                end
            endcase
        endfunction

        // one accepted input transfer
        function void take_byte(logic [7:0] c, logic last);
            logic [1:0] idx;
            logic [7:0] want;
            step_out.delete();
            if (mode == MODE_HALT)
                return;
            if (text_head)
            begin
                idx  = (mark_len > 2'd2) ? 2'd2 : mark_len;
                want = (idx == 2'd0) ? BOM_0 : (idx == 2'd1) ? BOM_1 : BOM_2;
                if (c == want)
                begin
                    if (idx == 2'd2)
                    begin
                        mark_bytes = 16'h0000;
                        mark_len   = 2'd0;
                        text_head  = 1'b0;
                    end
                    else
                    begin
                        mark_bytes = {mark_bytes[7:0], c};
                        mark_len   = idx + 2'd1;
                        if (last)
                            release_mark();
                    end
                end
                else
                begin
                    release_mark();
                    feed(c);
                end
            end
            else
            begin
                feed(c);
            end
            if (last)
            begin
                finish_text();
                if (mode != MODE_HALT)
                    restart();
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                pending = {pending, step_out[i]};
        endfunction

        // one accepted output transfer against the oldest owed token
        function void match_token(kind_t k, logic [7:0] d, err_t e, logic l,
                                  logic [4:0] pad);
            token_t want_tok;
            if (pending.size() == 0)
            begin
                $error("token with none owed: kind %0d byte %02h err %0d", k, d, e);
                errors++;
                return;
            end
            want_tok = pending.pop_front();
            checked++;
            if (k == KIND_ERR)
                seen_err = e;
            if (k !== want_tok.kind)
            begin
                $error("out_kind: expected %0d, got %0d", want_tok.kind, k);
                errors++;
            end
            if (d !== want_tok.data)
            begin
                $error("out_byte: expected %02h, got %02h", want_tok.data, d);
                errors++;
            end
            if (e !== want_tok.err)
            begin
                $error("error_code: expected %0d, got %0d", want_tok.err, e);
                errors++;
            end
            if (l !== want_tok.last)
            begin
                $error("run_last: expected %0b, got %0b", want_tok.last, l);
                errors++;
            end
            if (pad !== 5'd0)
            begin
                $error("tdata pad: expected 0, got %02h", pad);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import uct_pkg::*;
    import uct_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 160;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // [7:0] out_byte, [10:8] error_code, [15:11] zero
    logic [1:0]  m_tuser;   // [1:0] out_kind
    logic        m_tlast;   // run_last

    csv_tokens board = new();

    int tx_idle     = 33;
    int rx_idle     = 81;
    bit hold_req    = 1'b0;
    int cycle_count = 0;
    int bytes_sent  = 0;
    int texts_sent  = 0;

    always #5 clk = ~clk;

    utf8_csv_tokenizer u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // watchdog on the whole run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("utf8_csv_tokenizer regression: fail");
        $finish;
    end

    // token side: check each transfer, then pick the next tready
    // a single long hold-off is counted here once the stimulus asks for it
    initial
    begin : token_sink
        int held_cycles;
        held_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.match_token(kind_t'(m_tuser), m_tdata[7:0],
                                  err_t'(m_tdata[10:8]), m_tlast, m_tdata[15:11]);
            if (hold_req && held_cycles < HOLD_CYCLES)
            begin
                held_cycles++;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    // one byte transfer, with random gaps before it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_text(input byte_q_t t);
        foreach (t[i])
            send_byte(t[i], i == t.size() - 1);
        texts_sent++;
    endtask

    // append one byte to a text
    function automatic void add_byte(ref byte_q_t t, input logic [7:0] b);
        t = {t, b};
    endfunction

    function automatic logic [7:0] cont(input logic [7:0] lo, input logic [7:0] hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // ascii with none of the csv specials
    function automatic logic [7:0] plain_ascii();
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'h7F, 8'h01));
        while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    // one well-formed utf-8 character, never a csv special
    function automatic void add_char(ref byte_q_t t);
        logic [7:0] lead;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5:
            begin
                add_byte(t, plain_ascii());
            end
            6:
            begin
                add_byte(t, cont(8'hC2, 8'hDF));
                add_byte(t, cont(8'h80, 8'hBF));
            end
            7:
            begin
                lead = cont(8'hE0, 8'hEF);
                add_byte(t, lead);
                // E0 raises and ED lowers the bound of the next byte
                if (lead == 8'hE0)
                    add_byte(t, cont(8'hA0, 8'hBF));
                else if (lead == 8'hED)
                    add_byte(t, cont(8'h80, 8'h9F));
                else
                    add_byte(t, cont(8'h80, 8'hBF));
                add_byte(t, cont(8'h80, 8'hBF));
            end
            8:
            begin
                lead = cont(8'hF0, 8'hF4);
                add_byte(t, lead);
                if (lead == 8'hF0)
                    add_byte(t, cont(8'h90, 8'hBF));
                else if (lead == 8'hF4)
                    add_byte(t, cont(8'h80, 8'h8F));
                else
                    add_byte(t, cont(8'h80, 8'hBF));
                add_byte(t, cont(8'h80, 8'hBF));
                add_byte(t, cont(8'h80, 8'hBF));
            end
            default:
            begin
                // range edges of the multi-byte sequence lengths
                case ($urandom_range(5))
                    0: begin add_byte(t, 8'hC2); add_byte(t, 8'h80); end
                    1: begin add_byte(t, 8'hDF); add_byte(t, 8'hBF); end
                    2: begin add_byte(t, 8'hE0); add_byte(t, 8'hA0); add_byte(t, 8'h80); end
                    3: begin add_byte(t, 8'hED); add_byte(t, 8'h9F); add_byte(t, 8'hBF); end
                    4:
                    begin
                        add_byte(t, 8'hF0); add_byte(t, 8'h90);
                        add_byte(t, 8'h80); add_byte(t, 8'h80);
                    end
                    default:
                    begin
                        add_byte(t, 8'hF4); add_byte(t, 8'h8F);
                        add_byte(t, 8'hBF); add_byte(t, 8'hBF);
                    end
                endcase
            end
        endcase
    endfunction

    // empty, unquoted or quoted field; quoted ones carry doubled quotes,
    // crlf, lone cr, commas and lf as content
    function automatic void add_field(ref byte_q_t t, input bit plain_only);
        int n;
        int pick;
        pick = plain_only ? 1 : $urandom_range(7);
        if (pick == 0)
            return;
        if (pick < 4)
        begin
            n = $urandom_range(5, 1);
            repeat (n)
                add_char(t);
        end
        else
        begin
            add_byte(t, CH_QUOTE);
            n = $urandom_range(6);
            repeat (n)
            begin
                case ($urandom_range(9))
                    0: begin add_byte(t, CH_QUOTE); add_byte(t, CH_QUOTE); end
                    1: begin add_byte(t, CH_CR); add_byte(t, CH_LF); end
                    2: add_byte(t, CH_CR);
                    3: add_byte(t, CH_COMMA);
                    4: add_byte(t, CH_LF);
                    default: add_char(t);
                endcase
            end
            add_byte(t, CH_QUOTE);
        end
    endfunction

    // well-formed text: optional mark or a mark look-alike, 1..3 rows,
    // the last row may stop without a row end
    function automatic void make_text(ref byte_q_t t);
        int         rows;
        int         fields;
        int         shape;
        logic [7:0] second;
        t.delete();
        shape = $urandom_range(7);
        if (shape < 2)
        begin
            add_byte(t, BOM_0); add_byte(t, BOM_1); add_byte(t, BOM_2);
        end
        else if (shape == 2)
        begin
            // two mark bytes, then a third that breaks the mark
            add_byte(t, BOM_0); add_byte(t, BOM_1); add_byte(t, cont(8'h80, 8'hBE));
        end
        else if (shape == 3)
        begin
            second = cont(8'h80, 8'hBF);
            if (second == BOM_1)
                second = 8'hBC;
            add_byte(t, BOM_0); add_byte(t, second); add_byte(t, cont(8'h80, 8'hBF));
        end
        rows = $urandom_range(3, 1);
        for (int r = 0; r < rows; r++)
        begin
            fields = $urandom_range(4, 1);
            for (int f = 0; f < fields; f++)
            begin
                if (f != 0)
                    add_byte(t, CH_COMMA);
                // released look-alike bytes already opened an unquoted field
                add_field(t, (shape == 2 || shape == 3) && r == 0 && f == 0);
            end
            if (r < rows - 1 || $urandom_range(2) != 0)
            begin
                if ($urandom_range(1))
                begin
                    add_byte(t, CH_LF);
                end
                else
                begin
                    add_byte(t, CH_CR); add_byte(t, CH_LF);
                end
            end
        end
        if (t.size() == 0)
            add_byte(t, CH_LF);
    endfunction

    // closing text: aims at one of the four errors
    function automatic void make_broken_text(ref byte_q_t t);
        err_t aim;
        int   sub;
        t.delete();
        if ($urandom_range(1))
        begin
            add_field(t, 1'b0);
            add_byte(t, CH_COMMA);
        end
        aim = err_t'($urandom_range(4, 1));
        sub = $urandom_range(3);
        case (aim)
            ERR_UTF8:
            begin
                case (sub)
                    0: add_byte(t, CH_NUL);
                    1: add_byte(t, $urandom_range(1) ? cont(8'hC0, 8'hC1) : cont(8'hF5, 8'hFF));
                    2: begin add_byte(t, 8'hE0); add_byte(t, cont(8'h80, 8'h9F)); end
                    default: add_byte(t, 8'hF4);   // cut short by the end of text
                endcase
            end
            ERR_UNCLOSED:
            begin
                add_byte(t, CH_QUOTE);
                add_char(t);
                if (sub[0])
                    add_byte(t, CH_CR);
            end
            ERR_STRAY:
            begin
                add_char(t);
                add_byte(t, CH_QUOTE);
            end
            default:
            begin
                case (sub)
                    0:
                    begin
                        add_byte(t, CH_QUOTE); add_char(t); add_byte(t, CH_QUOTE);
                        add_byte(t, plain_ascii());
                    end
                    1:
                    begin
                        add_char(t); add_byte(t, CH_CR); add_byte(t, plain_ascii());
                    end
                    default:
                    begin
                        add_char(t); add_byte(t, CH_CR);
                    end
                endcase
            end
        endcase
    endfunction

    initial
    begin : stimulus
        byte_q_t text;
        int      start_bytes;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mark dropped, doubled quote, crlf in quotes, empty field before crlf
        text = '{BOM_0, BOM_1, BOM_2, CH_QUOTE, 8'h61, CH_QUOTE, CH_QUOTE, CH_CR,
                 CH_LF, CH_QUOTE, CH_COMMA, CH_CR, CH_LF};
        send_text(text);
        // held mark bytes released on the last byte: four tokens from one transfer
        text = '{BOM_0, BOM_1, 8'h80};
        send_text(text);
        // highest code point, then a trailing comma gives an empty last field
        text = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, CH_COMMA};
        send_text(text);
        // lowest byte, lone cr kept inside quotes, text ends on a closing quote
        text = '{8'h01, CH_COMMA, CH_QUOTE, CH_CR, 8'h7F, CH_QUOTE};
        send_text(text);

        // three pacing phases; the last one opens with the long output stall
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle = (phase == 0) ? 33 : (phase == 1) ? 81 : 0;
            rx_idle = (phase == 0) ? 81 : (phase == 1) ? 33 : 0;
            if (phase == 2)
                hold_req = 1'b1;
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES)
            begin
                make_text(text);
                send_text(text);
            end
        end

        // an error halts the block for good, so it only comes at the very end
        make_broken_text(text);
        send_text(text);
        // halted block has to stay silent whatever arrives
        repeat (8)
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("run covered %0d texts / %0d bytes over three pacing phases and a %0d-cycle stall",
                 texts_sent, bytes_sent, HOLD_CYCLES);
        $display("%0d tokens checked, closing text stopped with error code %0d",
                 board.checked, board.seen_err);
        if (board.errors == 0)
            $display("utf8_csv_tokenizer regression: pass");
        else
            $display("utf8_csv_tokenizer regression: fail");
        $finish;
    end

endmodule
